// File: hw/rtl/imufp_pkg.sv
// ----------------------------------------------------------------------------
// IMU frame parser package
// Shared constants for the byte-serial IMU frame parser and its checker.
// ----------------------------------------------------------------------------
package imufp_pkg;

    // Default frame length in bytes: header, type, data bytes and checksum.
    localparam int FRAME_BYTES_DEF = 11;

    localparam int DATA_W  = 8;
    localparam int WORD_W  = 16;
    localparam int KIND_W  = 2;
    localparam int POS_W   = 4;
    localparam int N_WORDS = 4;

    // Byte codes on the serial link.
    localparam logic [DATA_W-1:0] HDR_BYTE = 8'h55;
    localparam logic [DATA_W-1:0] TYPE_ACC = 8'h51;
    localparam logic [DATA_W-1:0] TYPE_GYR = 8'h52;
    localparam logic [DATA_W-1:0] TYPE_ANG = 8'h53;

    // Frame kind codes as reported on the result channel.
    localparam logic [KIND_W-1:0] KIND_ACC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GYR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ANG = 2'd2;

    typedef logic [WORD_W-1:0] t_word;

endpackage : imufp_pkg

// File: hw/rtl/imu_frame_parser.sv
// ----------------------------------------------------------------------------
// IMU frame parser
// Hunts for header and type bytes in a serial byte stream, assembles the
// little-endian data words of each frame and checks its 8-bit sum.
// ----------------------------------------------------------------------------
// The result register loads at the transfer of the checksum byte of its frame,
// and the result appears on the output in the cycle after that transfer.
// Throughput: one byte per cycle while not stalled; the per-byte state update
// is one small add and a few compares between the parse state registers and
// the result register. Reset (synchronous, active low) returns the parser to
// the header hunt and empties the result register.
module imu_frame_parser #(
    parameter int FRAME_BYTES = imufp_pkg::FRAME_BYTES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Byte input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [imufp_pkg::DATA_W-1:0]          i_data_byte,
    // Result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [imufp_pkg::KIND_W-1:0]          o_frame_kind,
    output logic signed [imufp_pkg::WORD_W-1:0]   o_word_one,
    output logic signed [imufp_pkg::WORD_W-1:0]   o_word_two,
    output logic signed [imufp_pkg::WORD_W-1:0]   o_word_three,
    output logic signed [imufp_pkg::WORD_W-1:0]   o_word_four,
    output logic                                  o_checksum_good
);
    import imufp_pkg::*;

    // Parse phase codes. The unused code behaves as the hunt.
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    // Byte position of the checksum byte within a frame.
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] DATA_POS = POS_W'(2);

    // Parse state.
    logic [1:0]          r_phase,    n_phase;
    logic [POS_W-1:0]    r_pos,      n_pos;
    logic [DATA_W-1:0]   r_sum,      n_sum;
    logic [KIND_W-1:0]   r_kind,     n_kind;
    logic [DATA_W-1:0]   r_low,      n_low;
    t_word               r_words [N_WORDS];
    t_word               n_words [N_WORDS];

    // Result register.
    logic                r_out_valid, n_out_valid;
    logic [KIND_W-1:0]   r_out_kind;
    t_word               r_out_words [N_WORDS];
    logic                r_out_good;

    logic                w_in_xfer;
    logic                w_frame_end;
    logic [POS_W-1:0]    w_data_idx;

    // The checksum byte is the only byte that produces a result, and whether
    // the next byte is one depends on the parse state alone. The input is
    // held off only when that byte would land on a result still waiting.
    assign w_frame_end = (r_phase == PH_DATA) && (r_pos >= LAST_POS);
    assign o_stall     = r_out_valid && i_stall && w_frame_end;
    assign w_in_xfer   = i_valid && !o_stall;

    // Offset of the current byte within the data field.
    assign w_data_idx  = r_pos - DATA_POS;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_kind  = r_kind;
        n_low   = r_low;
        for (int k = 0; k < N_WORDS; k++) begin
            n_words[k] = r_words[k];
        end

        if (w_in_xfer) begin
            unique case (r_phase)
                PH_TYPE: begin
                    // A repeated header keeps waiting for the type byte.
                    if (i_data_byte != HDR_BYTE) begin
                        if (i_data_byte == TYPE_ACC || i_data_byte == TYPE_GYR
                                || i_data_byte == TYPE_ANG) begin
                            n_kind  = KIND_W'(i_data_byte - TYPE_ACC);
                            n_sum   = HDR_BYTE + i_data_byte;
                            n_pos   = DATA_POS;
                            n_low   = '0;
                            n_phase = PH_DATA;
                            for (int k = 0; k < N_WORDS; k++) begin
                                n_words[k] = '0;
                            end
                        end else begin
                            // Unknown type: back to the hunt, the byte is dropped.
                            n_phase = PH_HUNT;
                            n_pos   = '0;
                        end
                    end
                end
                PH_DATA: begin
                    if (w_frame_end) begin
                        n_phase = PH_HUNT;
                        n_pos   = '0;
                    end else begin
                        // Even offsets hold the low byte; odd offsets complete a
                        // word. Data past the fourth word is summed only.
                        if (!w_data_idx[0]) begin
                            n_low = i_data_byte;
                        end else if (!w_data_idx[POS_W-1]) begin
                            n_words[w_data_idx[2:1]] = {i_data_byte, r_low};
                        end
                        n_sum = r_sum + i_data_byte;
                        n_pos = r_pos + POS_W'(1);
                    end
                end
                default: begin
                    if (i_data_byte == HDR_BYTE) begin
                        n_phase = PH_TYPE;
                        n_pos   = POS_W'(1);
                    end else begin
                        n_phase = PH_HUNT;
                        n_pos   = '0;
                    end
                end
            endcase
        end
    end

    // The result register empties on an output transfer and reloads when
    // the checksum byte arrives.
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (w_in_xfer && w_frame_end) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Frame contents are always rewritten at the type byte before use.
    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_kind <= n_kind;
        r_low  <= n_low;
        for (int k = 0; k < N_WORDS; k++) begin
            r_words[k] <= n_words[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_frame_end) begin
            r_out_kind <= r_kind;
            r_out_good <= (r_sum == i_data_byte);
            for (int k = 0; k < N_WORDS; k++) begin
                r_out_words[k] <= r_words[k];
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_frame_kind    = r_out_kind;
    assign o_word_one      = $signed(r_out_words[0]);
    assign o_word_two      = $signed(r_out_words[1]);
    assign o_word_three    = $signed(r_out_words[2]);
    assign o_word_four     = $signed(r_out_words[3]);
    assign o_checksum_good = r_out_good;

endmodule : imu_frame_parser

// File: hw/rtl/imufp_checker.sv
// ----------------------------------------------------------------------------
// IMU frame parser checker
// Port-level assertions on the result channel and the input hold-off.
// ----------------------------------------------------------------------------
module imufp_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_stall,
    input  logic                                  o_valid,
    input  logic                                  i_stall,
    input  logic [imufp_pkg::KIND_W-1:0]          o_frame_kind,
    input  logic signed [imufp_pkg::WORD_W-1:0]   o_word_one,
    input  logic signed [imufp_pkg::WORD_W-1:0]   o_word_two,
    input  logic signed [imufp_pkg::WORD_W-1:0]   o_word_three,
    input  logic signed [imufp_pkg::WORD_W-1:0]   o_word_four,
    input  logic                                  o_checksum_good
);
    import imufp_pkg::*;

    // A stalled result stays in place until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_kind)
            && $stable(o_word_one) && $stable(o_word_two) && $stable(o_word_three)
            && $stable(o_word_four) && $stable(o_checksum_good))
        else $error("result changed while stalled");

    // Only the three known frame kinds are reported.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_kind == KIND_ACC || o_frame_kind == KIND_GYR
            || o_frame_kind == KIND_ANG))
        else $error("invalid frame kind");

    // The input is held off only behind a waiting, stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    // Reset empties the result register and releases the input.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result channel not cleared by reset");

endmodule : imufp_checker

bind imu_frame_parser imufp_checker u_imufp_checker (.*);
